@@ rtl/six_axis_moving_average_assert.svh @@
// Assertion macros for the checker in sma_check.sv.
`ifndef SIX_AXIS_MOVING_AVERAGE_ASSERT_SVH
`define SIX_AXIS_MOVING_AVERAGE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SMA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sma_pkg.sv @@
`default_nettype none

package sma_pkg;

  localparam int SMA_WINDOW   = 10;
  localparam int SMA_CHANNELS = 6;
  localparam int SMA_DATA_W   = 16;

  typedef logic signed [SMA_DATA_W-1:0] sma_sample_t;

  typedef struct packed {
    logic load;
    logic abs_en;
    logic mul_en;
    logic out_en;
  } sma_ctl_t;

endpackage

`default_nettype wire

@@ rtl/sma_lane.sv @@
`default_nettype none

module sma_lane import sma_pkg::*; #(
  parameter int WINDOW = SMA_WINDOW
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire sma_ctl_t    ctl,
  input  wire sma_sample_t sample,
  output sma_sample_t      avg
);

  localparam int LOG_W   = $clog2(WINDOW);
  localparam int SUM_W   = SMA_DATA_W + LOG_W;
  localparam int MAG_W   = SUM_W;
  localparam int SHIFT   = MAG_W + LOG_W;
  localparam int RECIP_W = MAG_W + 1;
  localparam int PROD_W  = MAG_W + RECIP_W;
  localparam int Q_W     = SMA_DATA_W + 1;
  localparam longint unsigned RECIP_L = ((64'd1 << SHIFT) + WINDOW - 1) / WINDOW;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

  sma_sample_t              tap_r [WINDOW];
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic [MAG_W-1:0]         mag_r;
  logic [MAG_W-1:0]         mag_nxt;
  logic                     neg2_r;
  logic [PROD_W-1:0]        prod_r;
  logic [PROD_W-1:0]        prod_nxt;
  logic                     neg3_r;
  logic [Q_W-1:0]           quo;
  logic [Q_W-1:0]           res;
  sma_sample_t              avg_r;

  assign sum_nxt  = sum_r + SUM_W'(sample) - SUM_W'(tap_r[WINDOW-1]);
  assign mag_nxt  = sum_r[SUM_W-1] ? MAG_W'(-sum_r) : MAG_W'(sum_r);
  assign prod_nxt = PROD_W'(mag_r) * PROD_W'(RECIP);
  assign quo      = prod_r[SHIFT +: Q_W];
  assign res      = neg3_r ? Q_W'(-quo) : quo;
  assign avg      = avg_r;

  // advance the window and the running sum on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      for (int k = 0; k < WINDOW; k++) begin
        tap_r[k] <= '0;
      end
    end else if (ctl.load) begin
      sum_r    <= sum_nxt;
      tap_r[0] <= sample;
      for (int k = 1; k < WINDOW; k++) begin
        tap_r[k] <= tap_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.abs_en) begin
      mag_r  <= mag_nxt;
      neg2_r <= sum_r[SUM_W-1];
    end
    if (ctl.mul_en) begin
      prod_r <= prod_nxt;
      neg3_r <= neg2_r;
    end
    if (ctl.out_en) begin
      avg_r <= res[SMA_DATA_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ rtl/six_axis_moving_average.sv @@
// Stages: sum, magnitude, product and output registers precede out_valid.
// Throughput: one sample per cycle unless out_ready back-pressure fills the
// stages; a stalled output holds its result, empty stages still take samples.
// Reset: synchronous active-low rst_n clears the sample windows, the running
// sums and all stage valids; the first WINDOW-1 averages include zeros.
`default_nettype none

module six_axis_moving_average import sma_pkg::*; #(
  parameter int WINDOW = SMA_WINDOW
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire sma_sample_t in_accel_x,
  input  wire sma_sample_t in_accel_y,
  input  wire sma_sample_t in_accel_z,
  input  wire sma_sample_t in_gyro_x,
  input  wire sma_sample_t in_gyro_y,
  input  wire sma_sample_t in_gyro_z,
  output logic             out_valid,
  input  wire logic        out_ready,
  output sma_sample_t      out_avg_accel_x,
  output sma_sample_t      out_avg_accel_y,
  output sma_sample_t      out_avg_accel_z,
  output sma_sample_t      out_avg_gyro_x,
  output sma_sample_t      out_avg_gyro_y,
  output sma_sample_t      out_avg_gyro_z
);

  logic [3:0]  vld_r;
  logic [3:0]  vld_nxt;
  logic [3:0]  take;
  sma_ctl_t    ctl;
  sma_sample_t smp [SMA_CHANNELS];
  sma_sample_t avg [SMA_CHANNELS];

  assign take[3]  = !vld_r[3] || out_ready;
  assign take[2]  = !vld_r[2] || take[3];
  assign take[1]  = !vld_r[1] || take[2];
  assign take[0]  = !vld_r[0] || take[1];
  assign in_ready = take[0];

  assign ctl.load   = in_valid && take[0];
  assign ctl.abs_en = take[1];
  assign ctl.mul_en = take[2];
  assign ctl.out_en = take[3];

  assign vld_nxt[0] = take[0] ? in_valid : vld_r[0];
  assign vld_nxt[1] = take[1] ? vld_r[0] : vld_r[1];
  assign vld_nxt[2] = take[2] ? vld_r[1] : vld_r[2];
  assign vld_nxt[3] = take[3] ? vld_r[2] : vld_r[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign smp[0] = in_accel_x;
  assign smp[1] = in_accel_y;
  assign smp[2] = in_accel_z;
  assign smp[3] = in_gyro_x;
  assign smp[4] = in_gyro_y;
  assign smp[5] = in_gyro_z;

  for (genvar c = 0; c < SMA_CHANNELS; c++) begin : g_lane
    sma_lane #(
      .WINDOW(WINDOW)
    ) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .sample(smp[c]),
      .avg   (avg[c])
    );
  end

  assign out_valid       = vld_r[3];
  assign out_avg_accel_x = avg[0];
  assign out_avg_accel_y = avg[1];
  assign out_avg_accel_z = avg[2];
  assign out_avg_gyro_x  = avg[3];
  assign out_avg_gyro_y  = avg[4];
  assign out_avg_gyro_z  = avg[5];

endmodule

`default_nettype wire

@@ rtl/sma_check.sv @@
`default_nettype none
`include "six_axis_moving_average_assert.svh"

module sma_check import sma_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire sma_sample_t out_avg_accel_x,
  input wire sma_sample_t out_avg_gyro_z
);

  `SMA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_avg_accel_x) && $stable(out_avg_gyro_z),
    "stalled result changed")

  `SMA_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready,
    "input stalled with empty output")

  `SMA_ASSERT_NOW(a_stall_cause, !in_ready, out_valid && !out_ready,
    "input stalled without output backpressure")

  `SMA_ASSERT_NOW(a_reset_empty, $past(!rst_n), !out_valid,
    "result valid right after reset")

endmodule

bind six_axis_moving_average sma_check u_sma_check (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_avg_accel_x(out_avg_accel_x),
  .out_avg_gyro_z (out_avg_gyro_z)
);

`default_nettype wire
